// ----- rtl/sgdmf_pkg.sv -----
// Shared types, constants and fixed-point helpers for the SGD factor update block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sgdmf_pkg;

  // Default sizes
  localparam int RANK_DEF       = 16;
  localparam int LEFT_ROWS_DEF  = 1024;
  localparam int RIGHT_ROWS_DEF = 1024;

  // Fixed field widths
  localparam int IDX_W     = 10;
  localparam int ELEM_W    = 4;
  localparam int DEG_W     = 16;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 17;
  localparam int MU_W      = 31;
  localparam int CFG_IDX_W = 2;
  localparam int QUO_W     = 32;
  localparam int DVD_W     = 48;

  // Register reset values
  localparam logic [STEP_W-1:0] STEP_RST  = 17'd655;
  localparam logic [STEP_W-1:0] DECAY_RST = 17'd58982;
  localparam logic [MU_W-1:0]   MU_RST    = 31'd6554;
  localparam logic [STEP_W-1:0] STEP_MAX  = 17'h1FFFF;

  typedef enum logic [2:0] {
    OP_WR_LEFT  = 3'd0,
    OP_WR_RIGHT = 3'd1,
    OP_RD_LEFT  = 3'd2,
    OP_RD_RIGHT = 3'd3,
    OP_TRAIN    = 3'd4,
    OP_PROBE    = 3'd5,
    OP_EPOCH    = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_MEAN = 2'd0,
    CFG_INIT_STEP   = 2'd1,
    CFG_STEP_DECAY  = 2'd2,
    CFG_REG_MU      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SM_MU_STEP    = 2'd0,
    SM_STEP_ERR   = 2'd1,
    SM_STEP_DECAY = 2'd2
  } smul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_WRITE,
    S_READ,
    S_DOT,
    S_DOT_DRAIN,
    S_ERR,
    S_ESTEP,
    S_EVAL,
    S_DIV_WAIT,
    S_UPD,
    S_UPD_DRAIN,
    S_EPOCH,
    S_EPOCH_SAT,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      in_load;
    logic      base_load;
    logic      acc_clr;
    logic      wr_elem;
    logic      rd_en;
    logic      rd_elem;
    logic      upd;
    logic      smul_en;
    smul_sel_t smul_sel;
    logic      div_start;
    logic      err_load;
    logic      e_load;
    logic      shr_load;
    logic      step_load;
    logic      res_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic fault;
    logic pipe_busy;
    logic div_busy;
  } sts_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Q16.16 product rescale: floor by 2^16, then saturate
  function automatic logic signed [31:0] qmul(input logic signed [65:0] p);
    return sat32(p >>> 16);
  endfunction

  // Row index wrap by restoring reduction against n shifted down
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] v,
                                               input int unsigned n);
    logic [31:0] r;
    r = 32'(v);
    for (int j = IDX_W - 1; j >= 0; j--) begin
      if (r >= (32'(n) << j)) begin
        r = r - (32'(n) << j);
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sgd_matrix_factorization_update.sv -----
// Top level of the SGD matrix factorization update block.
// Depends on sgdmf_pkg, sgdmf_ctrl, sgdmf_datapath (with sgdmf_div).
//
//   channel | handshake             | word
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | op, row/col/element index, value, rating,
//           |                       | row/col degree
//   out     | out_valid / out_ready | read_value, prediction_error, degree_fault
//   cfg     | cfg_we                | cfg_index, cfg_wdata (no wait, no readback)
//
// One word at a time. Train: the 32-step degree dividers overlap the dot product
// walk, which reads one element per cycle from each store.
// A new word is taken while the previous result waits in the output register.
// Synchronous active-low reset clears control and config; factor stores are not
// cleared and must be written before use.
`default_nettype none

module sgd_matrix_factorization_update import sgdmf_pkg::*; #(
  parameter int RANK       = RANK_DEF,
  parameter int LEFT_ROWS  = LEFT_ROWS_DEF,
  parameter int RIGHT_ROWS = RIGHT_ROWS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               in_op,
  input  wire logic [IDX_W-1:0]         in_row_index,
  input  wire logic [IDX_W-1:0]         in_col_index,
  input  wire logic [ELEM_W-1:0]        in_element_index,
  input  wire logic signed [DATA_W-1:0] in_factor_value,
  input  wire logic signed [DATA_W-1:0] in_rating,
  input  wire logic [DEG_W-1:0]         in_row_degree,
  input  wire logic [DEG_W-1:0]         in_col_degree,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic signed [DATA_W-1:0]      out_prediction_error,
  output logic                          out_degree_fault
);

  localparam int KI = (RANK > 1) ? $clog2(RANK) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [KI-1:0] rd_k;

  sgdmf_ctrl #(.RANK(RANK)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_k      (rd_k)
  );

  sgdmf_datapath #(
    .RANK       (RANK),
    .LEFT_ROWS  (LEFT_ROWS),
    .RIGHT_ROWS (RIGHT_ROWS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .rd_k                 (rd_k),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_op                (in_op),
    .in_row_index         (in_row_index),
    .in_col_index         (in_col_index),
    .in_element_index     (in_element_index),
    .in_factor_value      (in_factor_value),
    .in_rating            (in_rating),
    .in_row_degree        (in_row_degree),
    .in_col_degree        (in_col_degree),
    .out_read_value       (out_read_value),
    .out_prediction_error (out_prediction_error),
    .out_degree_fault     (out_degree_fault)
  );

endmodule

`default_nettype wire

// ----- rtl/sgdmf_div.sv -----
// Bit-serial divider: floor(dividend / divisor / 2^16), one quotient bit per cycle.
// Depends on sgdmf_pkg for widths.
`default_nettype none

module sgdmf_div import sgdmf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DEG_W-1:0] divisor,
  output logic                  busy,
  output logic [QUO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DEG_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEG_W:0]   rem2;
  logic             qbit;

  // One restoring step over the top dividend bit
  always_comb begin
    rem2    = {rem_r, dvd_r[DVD_W-1]};
    qbit    = (rem2 >= {1'b0, divisor});
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      cnt_nxt = CNT_W'(QUO_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = dvd_r << 1;
      rem_nxt = qbit ? DEG_W'(rem2 - {1'b0, divisor}) : rem2[DEG_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/sgdmf_datapath.sv -----
// Datapath: factor memories, read/multiply/writeback pipeline, scalar multiplier,
// config registers, result register. Depends on sgdmf_pkg and sgdmf_div.
`default_nettype none

module sgdmf_datapath import sgdmf_pkg::*; #(
  parameter int RANK       = RANK_DEF,
  parameter int LEFT_ROWS  = LEFT_ROWS_DEF,
  parameter int RIGHT_ROWS = RIGHT_ROWS_DEF,
  localparam int KI        = (RANK > 1) ? $clog2(RANK) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  input  wire logic [KI-1:0]            rd_k,
  output sts_t                          sts,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_wdata,
  input  wire logic [2:0]               in_op,
  input  wire logic [IDX_W-1:0]         in_row_index,
  input  wire logic [IDX_W-1:0]         in_col_index,
  input  wire logic [ELEM_W-1:0]        in_element_index,
  input  wire logic signed [DATA_W-1:0] in_factor_value,
  input  wire logic signed [DATA_W-1:0] in_rating,
  input  wire logic [DEG_W-1:0]         in_row_degree,
  input  wire logic [DEG_W-1:0]         in_col_degree,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic signed [DATA_W-1:0]      out_prediction_error,
  output logic                          out_degree_fault
);

  localparam int LDEPTH = LEFT_ROWS * RANK;
  localparam int RDEPTH = RIGHT_ROWS * RANK;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int ACC_W  = 49 + $clog2(RANK + 1);

  // Config and step registers; the initial step only loads the current step
  logic signed [DATA_W-1:0] gm_r;
  logic [STEP_W-1:0]        decay_r, step_r, step_nxt;
  logic [MU_W-1:0]          mu_r;

  // Latched input word
  op_t                      op_r;
  logic [IDX_W-1:0]         row_r, col_r;
  logic [ELEM_W-1:0]        elem_r;
  logic signed [DATA_W-1:0] fval_r, rating_r;
  logic [DEG_W-1:0]         rdeg_r, cdeg_r;
  logic [LAW-1:0]           lbase_r;
  logic [RAW-1:0]           rbase_r;
  logic                     elem_ok, fault;

  // Memories
  logic [DATA_W-1:0]        lmem [LDEPTH];
  logic [DATA_W-1:0]        rmem [RDEPTH];
  logic                     lwe, rwe;
  logic [LAW-1:0]           lwa, lra;
  logic [RAW-1:0]           rwa, rra;
  logic [DATA_W-1:0]        lwd, rwd;

  // Pipeline
  logic signed [DATA_W-1:0] lrd_r, rrd_r;
  logic                     v1_r, v2_r, md1_r, md2_r;
  logic [KI-1:0]            k1_r, k2_r;
  logic signed [63:0]       p0_r, p1_r, p2_r, p3_r;
  logic signed [DATA_W-1:0] mul_b0;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DATA_W-1:0] new_l, new_r;

  // Scalar path
  logic signed [32:0]       sa, sb;
  logic signed [65:0]       smul_r;
  logic signed [DATA_W-1:0] err_r, err_nxt, e_r, e_nxt, t_step;
  logic signed [DATA_W-1:0] fl_r, fr_r, fl_nxt, fr_nxt;
  logic [17:0]              epoch_s;
  logic                     ldiv_busy, rdiv_busy;
  logic [QUO_W-1:0]         lq, rq;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r    <= '0;
      decay_r <= DECAY_RST;
      mu_r    <= MU_RST;
      step_r  <= STEP_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GLOBAL_MEAN: gm_r <= cfg_wdata;
          CFG_INIT_STEP:   step_r  <= cfg_wdata[STEP_W-1:0];
          CFG_STEP_DECAY:  decay_r <= cfg_wdata[STEP_W-1:0];
          CFG_REG_MU:      mu_r    <= cfg_wdata[MU_W-1:0];
          default: ;
        endcase
      end else if (cmd.step_load) begin
        step_r <= step_nxt;
      end
    end
  end

  // Input word latch and row base addresses
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r     <= op_t'(in_op);
      row_r    <= in_row_index;
      col_r    <= in_col_index;
      elem_r   <= in_element_index;
      fval_r   <= in_factor_value;
      rating_r <= in_rating;
      rdeg_r   <= in_row_degree;
      cdeg_r   <= in_col_degree;
    end
    if (cmd.base_load) begin
      lbase_r <= LAW'(32'(wrap_idx(row_r, LEFT_ROWS)) * RANK);
      rbase_r <= RAW'(32'(wrap_idx(col_r, RIGHT_ROWS)) * RANK);
    end
  end

  assign elem_ok = ({28'd0, elem_r} < 32'(RANK));
  assign fault   = (op_r == OP_TRAIN) && ((rdeg_r == '0) || (cdeg_r == '0));

  // Memory port addressing
  always_comb begin
    lra = lbase_r + (cmd.rd_elem ? LAW'(elem_r) : LAW'(rd_k));
    rra = rbase_r + (cmd.rd_elem ? RAW'(elem_r) : RAW'(rd_k));
    lwe = 1'b0;
    rwe = 1'b0;
    lwa = lbase_r + LAW'(k2_r);
    rwa = rbase_r + RAW'(k2_r);
    lwd = new_l;
    rwd = new_r;
    if (cmd.wr_elem) begin
      lwa = lbase_r + LAW'(elem_r);
      rwa = rbase_r + RAW'(elem_r);
      lwd = fval_r;
      rwd = fval_r;
      lwe = elem_ok && (op_r == OP_WR_LEFT);
      rwe = elem_ok && (op_r == OP_WR_RIGHT);
    end else if (v2_r && md2_r) begin
      lwe = 1'b1;
      rwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      lmem[lwa] <= lwd;
    end
    if (rwe) begin
      rmem[rwa] <= rwd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lrd_r <= lmem[lra];
      rrd_r <= rmem[rra];
    end
  end

  // Pipeline control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en && !cmd.rd_elem;
      v2_r <= v1_r;
    end
  end

  // Multiply stage: dot uses p0 only, update uses all four
  assign mul_b0 = md1_r ? fl_r : rrd_r;

  always_ff @(posedge clk) begin
    k1_r  <= rd_k;
    md1_r <= cmd.upd;
    k2_r  <= k1_r;
    md2_r <= md1_r;
    p0_r  <= lrd_r * mul_b0;
    p1_r  <= rrd_r * e_r;
    p2_r  <= rrd_r * fr_r;
    p3_r  <= lrd_r * e_r;
  end

  // Writeback / accumulate stage
  always_comb begin
    new_l   = sat32(66'(qmul(66'(p0_r))) + 66'(qmul(66'(p1_r))));
    new_r   = sat32(66'(qmul(66'(p2_r))) + 66'(qmul(66'(p3_r))));
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (v2_r && !md2_r) begin
      acc_nxt = acc_r + ACC_W'(p0_r >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Scalar multiplier
  always_comb begin
    sa = 33'($signed({1'b0, step_r}));
    sb = 33'($signed({1'b0, decay_r}));
    case (cmd.smul_sel)
      SM_MU_STEP: begin
        sa = $signed({2'b00, mu_r});
        sb = 33'($signed({1'b0, step_r}));
      end
      SM_STEP_ERR:   sb = 33'(err_r);
      SM_STEP_DECAY: sb = 33'($signed({1'b0, decay_r}));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.smul_en) begin
      smul_r <= sa * sb;
    end
  end

  // Degree dividers for the two shrink factors
  sgdmf_div u_ldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (smul_r[DVD_W-1:0]),
    .divisor  (rdeg_r),
    .busy     (ldiv_busy),
    .quotient (lq)
  );

  sgdmf_div u_rdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (smul_r[DVD_W-1:0]),
    .divisor  (cdeg_r),
    .busy     (rdiv_busy),
    .quotient (rq)
  );

  // Scalar results
  always_comb begin
    err_nxt  = sat32(66'(acc_r) + 66'(gm_r) - 66'(rating_r));
    t_step   = qmul(smul_r);
    e_nxt    = (t_step == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -t_step;
    fl_nxt   = sat32(66'sd65536 - 66'($signed({1'b0, lq})));
    fr_nxt   = sat32(66'sd65536 - 66'($signed({1'b0, rq})));
    epoch_s  = smul_r[33:16];
    step_nxt = (epoch_s > 18'(STEP_MAX)) ? STEP_MAX : epoch_s[STEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      err_r <= err_nxt;
    end
    if (cmd.e_load) begin
      e_r <= e_nxt;
    end
    if (cmd.shr_load) begin
      fl_r <= fl_nxt;
      fr_r <= fr_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_read_value <= '0;
      if (elem_ok && (op_r == OP_RD_LEFT)) begin
        out_read_value <= lrd_r;
      end else if (elem_ok && (op_r == OP_RD_RIGHT)) begin
        out_read_value <= rrd_r;
      end
      out_prediction_error <= ((op_r == OP_TRAIN) || (op_r == OP_PROBE)) ? err_r : '0;
      out_degree_fault     <= fault;
    end
  end

  assign sts.op        = op_r;
  assign sts.fault     = fault;
  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.div_busy  = ldiv_busy || rdiv_busy;

endmodule

`default_nettype wire

// ----- rtl/sgdmf_ctrl.sv -----
// Controller: sequences each op through the datapath, owns the element counter
// and the result valid flag. Depends on sgdmf_pkg.
`default_nettype none

module sgdmf_ctrl import sgdmf_pkg::*; #(
  parameter int RANK = RANK_DEF,
  localparam int KI  = (RANK > 1) ? $clog2(RANK) : 1
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire sts_t    sts,
  output cmd_t         cmd,
  output logic [KI-1:0] rd_k
);

  state_t         state_r, state_nxt;
  logic [KI-1:0]  k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           k_last, out_free, do_div;

  assign k_last   = (k_r == KI'(RANK - 1));
  assign out_free = !out_valid_r || out_ready;
  assign do_div   = (sts.op == OP_TRAIN) && !sts.fault;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_PREP;
      S_PREP: begin
        unique case (sts.op) inside
          OP_WR_LEFT, OP_WR_RIGHT: state_nxt = S_WRITE;
          OP_RD_LEFT, OP_RD_RIGHT: state_nxt = S_READ;
          OP_TRAIN, OP_PROBE:      state_nxt = S_DOT;
          OP_EPOCH:                state_nxt = S_EPOCH;
          default:                 state_nxt = S_DONE;
        endcase
      end
      S_WRITE:     state_nxt = S_DONE;
      S_READ:      state_nxt = S_DONE;
      S_DOT:       if (k_last) state_nxt = S_DOT_DRAIN;
      S_DOT_DRAIN: if (!sts.pipe_busy) state_nxt = S_ERR;
      S_ERR:       state_nxt = do_div ? S_ESTEP : S_DONE;
      S_ESTEP:     state_nxt = S_EVAL;
      S_EVAL:      state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:  if (!sts.div_busy) state_nxt = S_UPD;
      S_UPD:       if (k_last) state_nxt = S_UPD_DRAIN;
      S_UPD_DRAIN: if (!sts.pipe_busy) state_nxt = S_DONE;
      S_EPOCH:     state_nxt = S_EPOCH_SAT;
      S_EPOCH_SAT: state_nxt = S_DONE;
      S_DONE:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.smul_sel = SM_MU_STEP;
    in_ready     = 1'b0;
    k_nxt        = k_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      S_PREP: begin
        cmd.base_load = 1'b1;
        cmd.acc_clr   = 1'b1;
        cmd.smul_en   = 1'b1;
        k_nxt         = '0;
      end
      S_WRITE: cmd.wr_elem = 1'b1;
      S_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_elem = 1'b1;
      end
      S_DOT: begin
        cmd.rd_en     = 1'b1;
        cmd.div_start = do_div && (k_r == '0);
        k_nxt         = k_last ? '0 : k_r + 1'b1;
      end
      S_ERR: cmd.err_load = 1'b1;
      S_ESTEP: begin
        cmd.smul_en  = 1'b1;
        cmd.smul_sel = SM_STEP_ERR;
      end
      S_EVAL: cmd.e_load = 1'b1;
      S_DIV_WAIT: cmd.shr_load = !sts.div_busy;
      S_UPD: begin
        cmd.rd_en = 1'b1;
        cmd.upd   = 1'b1;
        k_nxt     = k_last ? '0 : k_r + 1'b1;
      end
      S_EPOCH: begin
        cmd.smul_en  = 1'b1;
        cmd.smul_sel = SM_STEP_DECAY;
      end
      S_EPOCH_SAT: cmd.step_load = 1'b1;
      S_DONE: cmd.res_load = out_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rd_k      = k_r;

  // Checks
  a_no_update_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> !sts.fault)
    else $error("factor update entered with zero degree");

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP))
    else $error("accepted word did not start decode");

  a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented on completion");

  a_shrink_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shr_load |-> !sts.div_busy)
    else $error("shrink factor taken from busy divider");

endmodule

`default_nettype wire
